// ===== hw/rtl/rpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and the arctangent table for the rectangular/polar converter.
// No dependencies; the converter top and the checker import this package.

package rpc_pkg;

    // Iteration count of the CORDIC chain (counts above 32 behave as 32)
    localparam int CORDIC_STEPS = 24;
    localparam int RPC_STEPS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Pipeline: input stage, start-vector stage, one stage per step, two output stages
    localparam int RPC_STAGES   = RPC_STEPS + 4;

    // Working widths: coordinates carry 32 fraction bits, angles are Q30
    localparam int XY_W = 52;
    localparam int Z_W  = 36;

    localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [29:0]           GAIN_Q30    = 30'd652032874;

    // Operand form selector
    typedef enum logic [1:0] {
        FORM_RECT  = 2'd0,
        FORM_POLAR = 2'd1
    } t_form;

    // Per-item side information that travels down the pipeline
    typedef struct packed {
        logic               rect;
        logic               polar;
        logic               zero_vec;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_tag;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            5'd24: v = 36'sh00000003F;
            5'd25: v = 36'sh00000001F;
            5'd26: v = 36'sh00000000F;
            5'd27: v = 36'sh000000008;
            5'd28: v = 36'sh000000004;
            5'd29: v = 36'sh000000002;
            5'd30: v = 36'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the converter: request in, result out.
// Depends on nothing.

interface rpc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;

    modport source (output valid, action, value_a, value_b, input ready);
    modport sink   (input valid, action, value_a, value_b, output ready);
endinterface

interface rpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] magnitude;
    logic signed [31:0] angle;
    logic               form_error;

    modport source (output valid, coord_x, coord_y, magnitude, angle, form_error,
                    input ready);
    modport sink   (input valid, coord_x, coord_y, magnitude, angle, form_error,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rect_polar_converter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Rectangular <-> polar converter: fully unrolled CORDIC pipeline.
// Depends on rpc_pkg and the rpc_in_if / rpc_out_if channel interfaces.

// The block takes one request per clock unless a stalled output has filled the pipeline,
// and returns one result per request, in order. The pipeline is one input stage that
// forms the gain-scaled magnitude and reduces the angle, one stage that builds the
// start vector, one register stage per CORDIC step, then a stage for the gain
// multiply / rounding and a final output register. Every stage has its own valid
// bit and advances whenever its successor is free, so a stalled output only
// backs up the pipeline as far as bubbles allow and nothing is lost or repeated.
// Sustained rate is one vector per cycle while the output is not stalled; the length
// of the unrolled step chain sets the latency.

module rect_polar_converter_top
    import rpc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    rpc_in_if.sink     i_req,
    rpc_out_if.source  o_res
);

    localparam int N  = RPC_STEPS;
    localparam int NS = RPC_STAGES;

    // Saturate a 36-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (!v[35] && (v[34:31] != 4'h0)) begin
            r = 32'sh7FFFFFFF;
        end else if (v[35] && (v[34:31] != 4'hF)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ---------------- handshake: per-stage advance ----------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_adv;

    assign w_adv[NS-1] = !r_v[NS-1] || o_res.ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_adv
        assign w_adv[k] = !r_v[k] || w_adv[k+1];
    end
    assign i_req.ready = w_adv[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: decode, gain product, angle wrap ----------------
    t_tag                   n_s0_tag, r_s0_tag;
    logic signed [62:0]     n_s0_prod, r_s0_prod;
    logic signed [Z_W-1:0]  n_s0_z, r_s0_z;
    logic signed [Z_W-1:0]  zb;

    always_comb begin
        n_s0_tag.rect     = 1'b0;
        n_s0_tag.polar    = 1'b0;
        case (i_req.action)
            FORM_RECT:  n_s0_tag.rect  = 1'b1;
            FORM_POLAR: n_s0_tag.polar = 1'b1;
            default: ;
        endcase
        n_s0_tag.zero_vec = (i_req.value_a == 32'sd0) && (i_req.value_b == 32'sd0);
        n_s0_tag.a        = i_req.value_a;
        n_s0_tag.b        = i_req.value_b;

        n_s0_prod = i_req.value_a * $signed({1'b0, GAIN_Q30});

        // Q4.28 -> Q30, then fold into [-pi, pi]
        zb = {{2{i_req.value_b[31]}}, i_req.value_b, 2'b00};
        if (zb > PI_Q30) begin
            n_s0_z = zb - TWO_PI_Q30;
        end else if (zb < -PI_Q30) begin
            n_s0_z = zb + TWO_PI_Q30;
        end else begin
            n_s0_z = zb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s0_tag  <= n_s0_tag;
            r_s0_prod <= n_s0_prod;
            r_s0_z    <= n_s0_z;
        end
    end

    // ---------------- stage 1: CORDIC start vector ----------------
    t_tag                   r_tag [0:N];
    logic signed [XY_W-1:0] r_cx  [0:N];
    logic signed [XY_W-1:0] r_cy  [0:N];
    logic signed [Z_W-1:0]  r_cz  [0:N];

    logic signed [XY_W-1:0] n_x0, n_y0, xa, ya, xm;
    logic signed [Z_W-1:0]  n_z0;

    always_comb begin
        xa = {{4{r_s0_tag.a[31]}}, r_s0_tag.a, 16'h0000};
        ya = {{4{r_s0_tag.b[31]}}, r_s0_tag.b, 16'h0000};
        xm = XY_W'(r_s0_prod >>> 14);
        if (r_s0_tag.rect) begin
            // left half plane: mirror and start from +/-pi
            if (r_s0_tag.a[31]) begin
                n_x0 = -xa;
                n_y0 = -ya;
                n_z0 = r_s0_tag.b[31] ? -PI_Q30 : PI_Q30;
            end else begin
                n_x0 = xa;
                n_y0 = ya;
                n_z0 = '0;
            end
        end else begin
            n_y0 = '0;
            if (r_s0_z > HALF_PI_Q30) begin
                n_x0 = -xm;
                n_z0 = r_s0_z - PI_Q30;
            end else if (r_s0_z < -HALF_PI_Q30) begin
                n_x0 = -xm;
                n_z0 = r_s0_z + PI_Q30;
            end else begin
                n_x0 = xm;
                n_z0 = r_s0_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_tag[0] <= r_s0_tag;
            r_cx[0]  <= n_x0;
            r_cy[0]  <= n_y0;
            r_cz[0]  <= n_z0;
        end
    end

    // ---------------- CORDIC steps, one register stage each ----------------
    for (genvar j = 0; j < N; j++) begin : g_step
        logic                   ccw;
        logic signed [XY_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  at;

        assign xs  = r_cx[j] >>> j;
        assign ys  = r_cy[j] >>> j;
        assign at  = atan_q30(5'(j));
        // vectoring drives y to zero, rotation drives z to zero
        assign ccw = r_tag[j].rect ? (r_cy[j] <= 0) : (r_cz[j] >= 0);

        always_ff @(posedge i_clk) begin
            if (w_adv[j+2]) begin
                r_tag[j+1] <= r_tag[j];
                if (ccw) begin
                    r_cx[j+1] <= r_cx[j] - ys;
                    r_cy[j+1] <= r_cy[j] + xs;
                    r_cz[j+1] <= r_cz[j] - at;
                end else begin
                    r_cx[j+1] <= r_cx[j] + ys;
                    r_cy[j+1] <= r_cy[j] - xs;
                    r_cz[j+1] <= r_cz[j] + at;
                end
            end
        end
    end

    // ---------------- post stage 1: gain multiply, rounding ----------------
    t_tag                   r_p1_tag;
    logic [63:0]            r_p1_hk;
    logic [29:0]            r_p1_lk;
    logic signed [31:0]     r_p1_ang, r_p1_cx, r_p1_cy;

    logic [XY_W-1:0]        u;
    logic [45:0]            lk_full;
    logic signed [XY_W-1:0] xr, yr;
    logic signed [Z_W-1:0]  zr;

    always_comb begin
        u       = (r_cx[N] > 0) ? XY_W'(r_cx[N]) : '0;
        lk_full = u[15:0] * GAIN_Q30;
        xr      = r_cx[N] + XY_W'(32768);
        yr      = r_cy[N] + XY_W'(32768);
        zr      = r_cz[N] + Z_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[N+2]) begin
            r_p1_tag <= r_tag[N];
            r_p1_hk  <= 64'(u[48:16]) * 64'(GAIN_Q30);
            r_p1_lk  <= lk_full[45:16];
            r_p1_ang <= sat32({{2{zr[Z_W-1]}}, zr[Z_W-1:2]});
            r_p1_cx  <= sat32(xr[XY_W-1:16]);
            r_p1_cy  <= sat32(yr[XY_W-1:16]);
        end
    end

    // ---------------- post stage 2: magnitude, result select ----------------
    logic signed [31:0] r_o_cx, r_o_cy, r_o_mag, r_o_ang;
    logic               r_o_err;
    logic signed [31:0] n_o_cx, n_o_cy, n_o_mag, n_o_ang;
    logic               n_o_err;
    logic [63:0]        p;
    logic signed [31:0] mag_sat;

    always_comb begin
        p       = r_p1_hk + 64'(r_p1_lk) + 64'(1 << 29);
        mag_sat = (p[63:61] != 3'b000) ? 32'sh7FFFFFFF : $signed(p[61:30]);
        n_o_cx  = '0;
        n_o_cy  = '0;
        n_o_mag = '0;
        n_o_ang = '0;
        n_o_err = 1'b0;
        if (r_p1_tag.rect) begin
            n_o_cx = r_p1_tag.a;
            n_o_cy = r_p1_tag.b;
            if (!r_p1_tag.zero_vec) begin
                n_o_mag = mag_sat;
                n_o_ang = r_p1_ang;
            end
        end else if (r_p1_tag.polar) begin
            n_o_cx  = r_p1_cx;
            n_o_cy  = r_p1_cy;
            n_o_mag = r_p1_tag.a;
            n_o_ang = r_p1_tag.b;
        end else begin
            n_o_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[N+3]) begin
            r_o_cx  <= n_o_cx;
            r_o_cy  <= n_o_cy;
            r_o_mag <= n_o_mag;
            r_o_ang <= n_o_ang;
            r_o_err <= n_o_err;
        end
    end

    assign o_res.valid      = r_v[NS-1];
    assign o_res.coord_x    = r_o_cx;
    assign o_res.coord_y    = r_o_cy;
    assign o_res.magnitude  = r_o_mag;
    assign o_res.angle      = r_o_ang;
    assign o_res.form_error = r_o_err;

endmodule

`default_nettype wire

// ===== hw/rtl/rpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the converter, bound to rect_polar_converter_top.
// Depends on rpc_pkg for the pipeline depth.

module rpc_checker
    import rpc_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire signed [31:0] i_coord_x,
    input wire signed [31:0] i_coord_y,
    input wire signed [31:0] i_magnitude,
    input wire signed [31:0] i_angle,
    input wire               i_form_error
);

    localparam int CW = $clog2(RPC_STAGES + 2);

    // Requests in flight: accepted but not yet delivered
    logic [CW-1:0] r_cnt;
    logic          in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // No result without a request behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != '0))
        else $error("result shown with no request in flight");

    // Never more requests in flight than pipeline stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(RPC_STAGES))
        else $error("more requests in flight than stages");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_coord_x) && $stable(i_coord_y) &&
             $stable(i_magnitude) && $stable(i_angle) && $stable(i_form_error)))
        else $error("stalled result changed");

    // Bad form selector gives all-zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_form_error) |->
            (i_coord_x == 0 && i_coord_y == 0 && i_magnitude == 0 && i_angle == 0))
        else $error("error result with nonzero fields");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind rect_polar_converter_top rpc_checker u_rpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_coord_x    (o_res.coord_x),
    .i_coord_y    (o_res.coord_y),
    .i_magnitude  (o_res.magnitude),
    .i_angle      (o_res.angle),
    .i_form_error (o_res.form_error)
);

`default_nettype wire
